/* design/ir_biphase_pulse_decoder_top_defines.svh */
// Assertion macros for the infrared biphase pulse decoder.
`ifndef IR_BIPHASE_PULSE_DECODER_TOP_DEFINES_SVH
`define IR_BIPHASE_PULSE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IBPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibpd: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ibpd: next-cycle check failed");

`endif

/* design/ibpd_pkg.sv */
// Shared widths, defaults and types for the infrared biphase pulse decoder.
`timescale 1ns / 1ps

package ibpd_pkg;

  localparam int DUR_W   = 16;  // pulse duration in timer ticks
  localparam int TICK_W  = 13;  // half-bit period register
  localparam int TOL_W   = 8;   // tolerance register
  localparam int WORD_W  = 12;  // frame word
  localparam int CNT_W   = 4;   // data bit counter
  localparam int SC_W    = 2;   // start pulse counter
  localparam int CFG_W   = 13;  // widest register
  localparam int CFG_IDX_W = 1;

  localparam int FRAME_BITS_DEF   = 11;
  localparam int START_PULSES_DEF = 3;

  localparam logic [TICK_W-1:0] HALF_BIT_RESET = 13'd10;
  localparam logic [TOL_W-1:0]  TOL_RESET      = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd1;

  // Window hits for one, two and three nominal half-bit periods.
  typedef struct packed {
    logic one;
    logic two;
    logic three;
  } win_hits_t;

endpackage

/* design/ibpd_classify.sv */
// Open-window classification of one pulse duration against 1T, 2T and 3T.
`timescale 1ns / 1ps

module ibpd_classify (
  input  logic [ibpd_pkg::DUR_W-1:0]  duration,
  input  logic [ibpd_pkg::TICK_W-1:0] half_bit,
  input  logic [ibpd_pkg::TOL_W-1:0]  tolerance,
  output ibpd_pkg::win_hits_t         hits
);

  // 3 * (8191 + 255) and the 16-bit duration both fit in 18 signed bits.
  localparam int CMP_W = ibpd_pkg::DUR_W + 2;

  logic signed [CMP_W-1:0] t_s, tol_s, d_s;
  logic signed [CMP_W-1:0] lo1, hi1, lo2, hi2, lo3, hi3;

  assign t_s   = $signed({{(CMP_W-ibpd_pkg::TICK_W){1'b0}}, half_bit});
  assign tol_s = $signed({{(CMP_W-ibpd_pkg::TOL_W){1'b0}}, tolerance});
  assign d_s   = $signed({{(CMP_W-ibpd_pkg::DUR_W){1'b0}}, duration});

  // Lower bounds may go negative; a signed compare then admits everything.
  assign lo1 = t_s - tol_s;
  assign hi1 = t_s + tol_s;
  assign lo2 = lo1 <<< 1;
  assign hi2 = hi1 <<< 1;
  assign lo3 = lo2 + lo1;
  assign hi3 = hi2 + hi1;

  assign hits.one   = (lo1 < d_s) && (d_s < hi1);
  assign hits.two   = (lo2 < d_s) && (d_s < hi2);
  assign hits.three = (lo3 < d_s) && (d_s < hi3);

endmodule

/* design/ir_biphase_pulse_decoder_top.sv */
// Top level of the infrared biphase pulse-width decoder.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid / in_ready / in_pulse_duration): one beat per
//   infrared edge, carrying the timer ticks since the previous edge.
//   Result channel (out_valid / out_ready / out_*): exactly one beat per
//   input beat: a decoded bit, a finished frame word, a loss-of-sync flag,
//   or an all-zero beat when the edge only arms or advances start hunting.
//   Configuration (cfg_we / cfg_index / cfg_data): half-bit period at index
//   0, tolerance at index 1; write only while no beat is in flight.
// Timing
//   Input register, then result register: a beat enters the input register
//   when accepted and moves into the result register once that is free or
//   draining. One beat per cycle is sustained while out_ready stays high,
//   as the state update between the two registers is combinational.
// Reset and back-pressure
//   Synchronous active-low reset empties both stages, returns to idle and
//   loads the default period (10) and tolerance (1). While out_ready is low
//   the result holds, one more beat may still enter the input register,
//   and in_ready drops once both stages are full.

`include "ir_biphase_pulse_decoder_top_defines.svh"

module ir_biphase_pulse_decoder_top #(
  parameter int FRAME_BITS   = ibpd_pkg::FRAME_BITS_DEF,
  parameter int START_PULSES = ibpd_pkg::START_PULSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ibpd_pkg::DUR_W-1:0]       in_pulse_duration,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_bit_valid,
  output logic                             out_bit_value,
  output logic                             out_frame_done,
  output logic [ibpd_pkg::WORD_W-1:0]      out_frame_word,
  output logic                             out_sync_lost,
  // configuration
  input  logic                             cfg_we,
  input  logic [ibpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ibpd_pkg::CFG_W-1:0]       cfg_data
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic [ibpd_pkg::CNT_W-1:0] FRAME_LEN = ibpd_pkg::CNT_W'(FRAME_BITS);
  localparam logic [ibpd_pkg::SC_W-1:0]  SYNC_LAST = ibpd_pkg::SC_W'(START_PULSES - 1);
  localparam logic [ibpd_pkg::SC_W-1:0]  SC_ONE    = ibpd_pkg::SC_W'(1);
  localparam logic [ibpd_pkg::CNT_W-1:0] CNT_ONE   = ibpd_pkg::CNT_W'(1);

  // configuration registers
  logic [ibpd_pkg::TICK_W-1:0] half_bit_r;
  logic [ibpd_pkg::TOL_W-1:0]  tolerance_r;

  // input stage
  logic                         s1_valid_r;
  logic [ibpd_pkg::DUR_W-1:0]   s1_dur_r;
  logic                         s1_advance;

  // decoder state
  logic [1:0]                   phase_r, phase_nxt;
  logic [ibpd_pkg::SC_W-1:0]    start_count_r, start_count_nxt;
  logic [ibpd_pkg::WORD_W-1:0]  shift_word_r, shift_word_nxt;
  logic [ibpd_pkg::CNT_W-1:0]   bit_count_r, bit_count_nxt;

  // result register
  logic                         out_valid_r;
  logic                         bit_valid_r, bit_valid_nxt;
  logic                         bit_value_r, bit_value_nxt;
  logic                         frame_done_r, frame_done_nxt;
  logic [ibpd_pkg::WORD_W-1:0]  frame_word_r, frame_word_nxt;
  logic                         sync_lost_r, sync_lost_nxt;

  ibpd_pkg::win_hits_t          hits;
  logic                         new_bit;

  // Configuration writes land straight in the period and tolerance registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_bit_r  <= ibpd_pkg::HALF_BIT_RESET;
      tolerance_r <= ibpd_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ibpd_pkg::CFG_HALF_BIT:  half_bit_r  <= cfg_data[ibpd_pkg::TICK_W-1:0];
        ibpd_pkg::CFG_TOLERANCE: tolerance_r <= cfg_data[ibpd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register is free or draining.
  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dur_r <= in_pulse_duration;
    end
  end

  ibpd_classify u_classify (
    .duration  (s1_dur_r),
    .half_bit  (half_bit_r),
    .tolerance (tolerance_r),
    .hits      (hits)
  );

  // Pulses of one and three half-bit periods invert the previous bit, two repeat it.
  assign new_bit = (hits.one || hits.three) ? ~shift_word_r[0] : shift_word_r[0];

  always_comb begin
    phase_nxt       = phase_r;
    start_count_nxt = start_count_r;
    shift_word_nxt  = shift_word_r;
    bit_count_nxt   = bit_count_r;
    bit_valid_nxt   = 1'b0;
    bit_value_nxt   = 1'b0;
    frame_done_nxt  = 1'b0;
    frame_word_nxt  = '0;
    sync_lost_nxt   = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (hits.one) begin
          if (start_count_r < SYNC_LAST) begin
            start_count_nxt = start_count_r + SC_ONE;
          end else begin
            // sync reached: emit the start bit, which is not stored
            shift_word_nxt = '0;
            bit_count_nxt  = '0;
            phase_nxt      = PH_DATA;
            bit_valid_nxt  = 1'b1;
          end
        end else begin
          start_count_nxt = SC_ONE;
        end
      end
      PH_DATA: begin
        if (bit_count_r < FRAME_LEN) begin
          if (hits.one || hits.two || hits.three) begin
            shift_word_nxt = {shift_word_r[ibpd_pkg::WORD_W-2:0], new_bit};
            bit_valid_nxt  = 1'b1;
            bit_value_nxt  = new_bit;
          end else begin
            phase_nxt     = PH_IDLE;
            sync_lost_nxt = 1'b1;
          end
          bit_count_nxt = bit_count_r + CNT_ONE;
        end else begin
          // frame end: this edge is not classified
          frame_done_nxt = 1'b1;
          frame_word_nxt = shift_word_r;
          phase_nxt      = PH_IDLE;
        end
      end
      default: begin
        // idle, and the unused code: arm start hunting
        start_count_nxt = SC_ONE;
        phase_nxt       = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      start_count_r <= '0;
      shift_word_r  <= '0;
      bit_count_r   <= '0;
    end else if (s1_advance) begin
      phase_r       <= phase_nxt;
      start_count_r <= start_count_nxt;
      shift_word_r  <= shift_word_nxt;
      bit_count_r   <= bit_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: hold while stalled, load with each advancing beat.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      bit_valid_r  <= bit_valid_nxt;
      bit_value_r  <= bit_value_nxt;
      frame_done_r <= frame_done_nxt;
      frame_word_r <= frame_word_nxt;
      sync_lost_r  <= sync_lost_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bit_valid  = bit_valid_r;
  assign out_bit_value  = bit_value_r;
  assign out_frame_done = frame_done_r;
  assign out_frame_word = frame_word_r;
  assign out_sync_lost  = sync_lost_r;

  // A result beat reports at most one event.
  `IBPD_ASSERT_NOW(a_one_event, clk, rst_n, out_valid_r,
                   $onehot0({bit_valid_r, frame_done_r, sync_lost_r}))
  // In data the bit counter never runs past the frame length.
  `IBPD_ASSERT_NOW(a_count_bound, clk, rst_n, phase_r == PH_DATA, bit_count_r <= FRAME_LEN)
  // While hunting the start counter sits between one and the sync threshold.
  `IBPD_ASSERT_NOW(a_hunt_count, clk, rst_n, phase_r == PH_HUNT,
                   (start_count_r != '0) && (start_count_r <= SYNC_LAST))
  // A frame word is only reported straight after data, and drops to idle.
  `IBPD_ASSERT_NEXT(a_frame_idle, clk, rst_n, s1_advance && frame_done_nxt,
                    phase_r == PH_IDLE && out_valid_r && frame_done_r)

endmodule
